// ----- hw/rtl/tmrb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmrb_pkg
// Shared constants, types and helpers of the tagged message ring buffer.
// ----------------------------------------------------------------------------
package tmrb_pkg;

  // Sizing
  localparam int BUF_DEPTH   = 128;
  localparam int MAX_MSG_LEN = 32;
  localparam int TAG_LEN     = 6;
  localparam int INDEX_LIMIT = 128;

  localparam int PTR_W = $clog2(BUF_DEPTH);
  localparam int CNT_W = 8;
  localparam int BYTE_W = 8;

  // Eviction runs while the stored count is above this
  localparam int ROOM_LIMIT = BUF_DEPTH - MAX_MSG_LEN - TAG_LEN;

  // Item kinds
  localparam logic [1:0] KIND_PUT    = 2'd0;
  localparam logic [1:0] KIND_SAVE   = 2'd1;
  localparam logic [1:0] KIND_UNDO   = 2'd2;
  localparam logic [1:0] KIND_REMOVE = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DROPPED   = 2'd1;
  localparam logic [1:0] ST_TOO_LONG  = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // Ring memory access
  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [PTR_W-1:0]  raddr;
  } mem_req_t;

  // Result item from the sequencer
  typedef struct packed {
    logic             available;
    logic [CNT_W-1:0] stored_bytes;
    logic [CNT_W-1:0] pending_bytes;
    logic [CNT_W-1:0] last_index;
    logic [1:0]       status;
  } res_t;

  // Ring pointer increment with wrap
  function automatic logic [PTR_W-1:0] ptr_bump(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] q;
    if (p == PTR_W'(BUF_DEPTH - 1)) begin
      q = '0;
    end else begin
      q = p + PTR_W'(1);
    end
    return q;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/tagged_message_ring_buffer_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tagged_message_ring_buffer_unit
// Byte ring of tagged text messages with put, save, undo and remove items.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries one item: kind, char_byte,
//   timestamp, ack_index. Result channel out_valid/out_stall returns one
//   result per item: available, stored_bytes, pending_bytes, last_index,
//   status. An item moves on a clock edge with valid high and stall low.
//   Each item runs through the sequencer states before its result is valid:
//     undo and a zero character go straight to the result; put writes its
//     byte; save writes the six tag bytes and commits; remove walks the ring
//     with one ring read and one check per byte.
//   A put or save that starts a message first evicts head messages, with
//   one ring read and one check per evicted byte.
//   One item is in work at a time; in_stall is high while it runs.
//   The result sits in an output register; the next item is accepted while
//   it waits, but its own result holds in the sequencer until the register
//   frees. A stalled result stays stable.
//   Reset (rst_n low, synchronous) empties the ring and clears the index;
//   ring contents need no clearing pass.
// ----------------------------------------------------------------------------
module tagged_message_ring_buffer_unit import tmrb_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_kind,
  input  wire logic [BYTE_W-1:0] in_char_byte,
  input  wire logic [31:0]       in_timestamp,
  input  wire logic [BYTE_W-1:0] in_ack_index,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_available,
  output logic [CNT_W-1:0]       out_stored_bytes,
  output logic [CNT_W-1:0]       out_pending_bytes,
  output logic [CNT_W-1:0]       out_last_index,
  output logic [1:0]             out_status
);

  mem_req_t          mem_req;
  logic [BYTE_W-1:0] mem_rdata;
  logic              busy;
  logic              res_valid;
  logic              res_ready;
  res_t              res;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_res_r;

  // Ring memory
  tmrb_ram #(
    .DEPTH  (BUF_DEPTH),
    .ADDR_W (PTR_W),
    .DATA_W (BYTE_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  // Sequencer
  tmrb_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .busy         (busy),
    .in_kind      (in_kind),
    .in_char_byte (in_char_byte),
    .in_timestamp (in_timestamp),
    .in_ack_index (in_ack_index),
    .mem_req      (mem_req),
    .mem_rdata    (mem_rdata),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  assign in_stall = busy;

  // Output register
  assign res_ready = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_available     = out_res_r.available;
  assign out_stored_bytes  = out_res_r.stored_bytes;
  assign out_pending_bytes = out_res_r.pending_bytes;
  assign out_last_index    = out_res_r.last_index;
  assign out_status        = out_res_r.status;

endmodule
`default_nettype wire

// ----- hw/rtl/tmrb_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmrb_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tmrb_ram #(
  parameter int DEPTH  = 128,
  parameter int ADDR_W = 7,
  parameter int DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/tmrb_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmrb_ctrl
// Sequencer: ring pointers and counts, eviction and removal walks, tag writes.
// ----------------------------------------------------------------------------
module tmrb_ctrl import tmrb_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   busy,
  input  wire logic [1:0]        in_kind,
  input  wire logic [BYTE_W-1:0] in_char_byte,
  input  wire logic [31:0]       in_timestamp,
  input  wire logic [BYTE_W-1:0] in_ack_index,
  output mem_req_t               mem_req,
  input  wire logic [BYTE_W-1:0] mem_rdata,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output res_t                   res
);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ROOM = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_TAG  = 3'd3;
  localparam logic [2:0] S_POP  = 3'd4;
  localparam logic [2:0] S_CHK  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  // Record field phases during a walk
  localparam logic [2:0] PH_TEXT = 3'd0;
  localparam logic [2:0] PH_IDX  = 3'd5;

  localparam logic [2:0] TAG_LAST = 3'(TAG_LEN - 1);

  logic [2:0]        state_r, state_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  cm_ptr_r, cm_ptr_nxt;
  logic [CNT_W-1:0]  stored_r, stored_nxt;
  logic [CNT_W-1:0]  pending_r, pending_nxt;
  logic [CNT_W-1:0]  seq_r, seq_nxt;
  logic [1:0]        status_r, status_nxt;

  // Walk context
  logic [PTR_W-1:0]  head0_r, head0_nxt;
  logic [CNT_W-1:0]  size0_r, size0_nxt;
  logic [2:0]        phase_r, phase_nxt;
  logic              drop_one_r, drop_one_nxt;
  logic              from_room_r, from_room_nxt;
  logic [2:0]        tag_cnt_r, tag_cnt_nxt;

  // Captured item
  logic [1:0]        kind_r;
  logic [BYTE_W-1:0] char_r;
  logic [31:0]       ts_r;
  logic [BYTE_W-1:0] ack_r;

  logic [CNT_W-1:0]  seq_inc;
  logic [CNT_W-1:0]  next_idx;
  logic [BYTE_W-1:0] tag_byte;
  logic              pend_full;
  logic              need_room;

  assign seq_inc   = seq_r + CNT_W'(1);
  assign next_idx  = (seq_inc >= CNT_W'(INDEX_LIMIT)) ? CNT_W'(1) : seq_inc;
  assign pend_full = (pending_r >= CNT_W'(MAX_MSG_LEN));
  assign need_room = (stored_r != '0) && (int'(stored_r) > ROOM_LIMIT);

  // Tag byte: terminator, big-endian timestamp, sequence index
  always_comb begin
    case (tag_cnt_r)
      3'd0:    tag_byte = '0;
      3'd1:    tag_byte = ts_r[31:24];
      3'd2:    tag_byte = ts_r[23:16];
      3'd3:    tag_byte = ts_r[15:8];
      3'd4:    tag_byte = ts_r[7:0];
      default: tag_byte = next_idx;
    endcase
  end

  // Next-state logic
  always_comb begin
    state_nxt     = state_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    cm_ptr_nxt    = cm_ptr_r;
    stored_nxt    = stored_r;
    pending_nxt   = pending_r;
    seq_nxt       = seq_r;
    status_nxt    = status_r;
    head0_nxt     = head0_r;
    size0_nxt     = size0_r;
    phase_nxt     = phase_r;
    drop_one_nxt  = drop_one_r;
    from_room_nxt = from_room_r;
    tag_cnt_nxt   = tag_cnt_r;
    mem_req       = '0;
    mem_req.waddr = wr_ptr_r;
    mem_req.raddr = rd_ptr_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          status_nxt = ST_OK;
          case (in_kind)
            KIND_PUT: begin
              if (in_char_byte == '0) begin
                state_nxt = S_DONE;
              end else begin
                state_nxt = (pending_r == '0) ? S_ROOM : S_EXEC;
              end
            end
            KIND_SAVE: begin
              state_nxt = (pending_r == '0) ? S_ROOM : S_EXEC;
            end
            KIND_UNDO: begin
              wr_ptr_nxt  = cm_ptr_r;
              pending_nxt = '0;
              state_nxt   = S_DONE;
            end
            default: begin
              head0_nxt     = rd_ptr_r;
              size0_nxt     = stored_r;
              phase_nxt     = PH_TEXT;
              drop_one_nxt  = (in_ack_index == BYTE_W'(INDEX_LIMIT));
              from_room_nxt = 1'b0;
              state_nxt     = S_POP;
            end
          endcase
        end
      end

      // Evict head messages until a full message plus tag fits
      S_ROOM: begin
        if (need_room) begin
          head0_nxt     = rd_ptr_r;
          size0_nxt     = stored_r;
          phase_nxt     = PH_TEXT;
          drop_one_nxt  = 1'b1;
          from_room_nxt = 1'b1;
          state_nxt     = S_POP;
        end else begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        if (kind_r == KIND_PUT) begin
          if (pend_full) begin
            status_nxt = ST_DROPPED;
          end else begin
            mem_req.we    = 1'b1;
            mem_req.wdata = char_r;
            wr_ptr_nxt    = ptr_bump(wr_ptr_r);
            pending_nxt   = pending_r + CNT_W'(1);
          end
          state_nxt = S_DONE;
        end else if (pend_full) begin
          wr_ptr_nxt  = cm_ptr_r;
          pending_nxt = '0;
          status_nxt  = ST_TOO_LONG;
          state_nxt   = S_DONE;
        end else begin
          tag_cnt_nxt = '0;
          state_nxt   = S_TAG;
        end
      end

      // One tag byte a cycle, then commit
      S_TAG: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = tag_byte;
        wr_ptr_nxt    = ptr_bump(wr_ptr_r);
        pending_nxt   = pending_r + CNT_W'(1);
        tag_cnt_nxt   = tag_cnt_r + 3'd1;
        if (tag_cnt_r == TAG_LAST) begin
          cm_ptr_nxt  = ptr_bump(wr_ptr_r);
          stored_nxt  = stored_r + pending_r + CNT_W'(1);
          pending_nxt = '0;
          seq_nxt     = next_idx;
          state_nxt   = S_DONE;
        end
      end

      // Pop one byte, or finish when the ring ran dry
      S_POP: begin
        if (stored_r == '0) begin
          if (drop_one_r) begin
            state_nxt = from_room_r ? S_ROOM : S_DONE;
          end else begin
            rd_ptr_nxt = head0_r;
            stored_nxt = size0_r;
            status_nxt = ST_NOT_FOUND;
            state_nxt  = S_DONE;
          end
        end else begin
          mem_req.re = 1'b1;
          rd_ptr_nxt = ptr_bump(rd_ptr_r);
          stored_nxt = stored_r - CNT_W'(1);
          state_nxt  = S_CHK;
        end
      end

      // Examine the popped byte
      S_CHK: begin
        state_nxt = S_POP;
        if (phase_r == PH_TEXT) begin
          if (mem_rdata == '0) begin
            phase_nxt = phase_r + 3'd1;
          end
        end else if (phase_r == PH_IDX) begin
          phase_nxt = PH_TEXT;
          if (drop_one_r || (mem_rdata == ack_r)) begin
            state_nxt = from_room_r ? S_ROOM : S_DONE;
          end else if (stored_r == '0) begin
            rd_ptr_nxt = head0_r;
            stored_nxt = size0_r;
            status_nxt = ST_NOT_FOUND;
            state_nxt  = S_DONE;
          end
        end else begin
          phase_nxt = phase_r + 3'd1;
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rd_ptr_r  <= '0;
      wr_ptr_r  <= '0;
      cm_ptr_r  <= '0;
      stored_r  <= '0;
      pending_r <= '0;
      seq_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      wr_ptr_r  <= wr_ptr_nxt;
      cm_ptr_r  <= cm_ptr_nxt;
      stored_r  <= stored_nxt;
      pending_r <= pending_nxt;
      seq_r     <= seq_nxt;
    end
  end

  // Walk context and captured item
  always_ff @(posedge clk) begin
    status_r    <= status_nxt;
    head0_r     <= head0_nxt;
    size0_r     <= size0_nxt;
    phase_r     <= phase_nxt;
    drop_one_r  <= drop_one_nxt;
    from_room_r <= from_room_nxt;
    tag_cnt_r   <= tag_cnt_nxt;
    if ((state_r == S_IDLE) && in_valid) begin
      kind_r <= in_kind;
      char_r <= in_char_byte;
      ts_r   <= in_timestamp;
      ack_r  <= in_ack_index;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign res_valid = (state_r == S_DONE);

  always_comb begin
    res.available     = (stored_r != '0);
    res.stored_bytes  = stored_r;
    res.pending_bytes = pending_r;
    res.last_index    = seq_r;
    res.status        = status_r;
  end

endmodule
`default_nettype wire
